### hw/rtl/asfm_pkg.sv
// Package: field widths and constants for the approximate float multiplier.
package asfm_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpBias   = 127;
   localparam logic [12:0] HiddenOne = 13'h1000;

   typedef logic [WordWidth-1:0] word_type;

   // Partial products handed from the multiply stage to the assembly stage.
   typedef struct packed {
      logic        sign;
      logic        zero_in;
      logic        exp_zero;
      logic [7:0]  exp_a;
      logic [7:0]  exp_b;
      logic [25:0] hh;
      logic [13:0] hl_sh;
      logic [13:0] lh_sh;
   } part_type;
endpackage

### hw/rtl/approx_single_float_multiplier.sv
// Top level: approximate single-precision multiplier with stream ports.
// Usage:
//  - req_ channel carries one multiply transaction: tdata = {operand_b, operand_a}.
//  - rsp_ channel returns one product per transaction in tdata.
//  - Order: the operands are captured in the input register, and the product
//    is then captured in the result register, which drives rsp_tdata.
//  - Throughput: one transaction per cycle while the receiver does not stall;
//    the input and result registers each hold one item, set by the one-pass datapath.
//  - When the receiver stalls, the result register holds and the input
//    register fills; req_tready drops only when both are full.
//  - Reset (synchronous, active high) empties both registers.
//  - No rounding; overflow and underflow give a signed zero.
module approx_single_float_multiplier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] product
);
   import asfm_pkg::*;

   logic      in_vld_ff, in_vld_in;
   word_type  a_ff, b_ff;
   logic      out_vld_ff, out_vld_in;
   word_type  res_ff;
   part_type  part;
   word_type  product;
   logic      advance;

   asfm_split_mul u_mul (.operand_a(a_ff), .operand_b(b_ff), .part(part));
   asfm_assemble  u_asm (.part(part), .product(product));

   // move from input register to result register when result is free
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_ff <= req_tdata[31:0];
         b_ff <= req_tdata[63:32];
      end
      if (advance) begin
         res_ff <= product;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = res_ff;
endmodule

### hw/rtl/asfm_split_mul.sv
// Significand split and partial product generation.
module asfm_split_mul (
   input  asfm_pkg::word_type operand_a,
   input  asfm_pkg::word_type operand_b,
   output asfm_pkg::part_type part
);
   import asfm_pkg::*;

   logic [12:0] ah, bh;
   logic [10:0] al, bl;
   logic [23:0] hl, lh;

   // high part carries the hidden one, low part is the bottom 11 bits
   always_comb begin
      ah = {1'b0, operand_a[22:11]} + HiddenOne;
      bh = {1'b0, operand_b[22:11]} + HiddenOne;
      al = operand_a[10:0];
      bl = operand_b[10:0];
      hl = ah * bl;
      lh = al * bh;
      part.sign     = operand_a[31] ^ operand_b[31];
      part.zero_in  = (operand_a[30:0] == '0) || (operand_b[30:0] == '0);
      part.exp_zero = (operand_a[30:23] == '0) || (operand_b[30:23] == '0);
      part.exp_a    = operand_a[30:23];
      part.exp_b    = operand_b[30:23];
      part.hh       = ah * bh;
      part.hl_sh    = {1'b0, hl[23:11]};
      part.lh_sh    = {1'b0, lh[23:11]};
   end
endmodule

### hw/rtl/asfm_assemble.sv
// Sum, normalise, exponent range check and packing of the product.
module asfm_assemble (
   input  asfm_pkg::part_type part,
   output asfm_pkg::word_type product
);
   import asfm_pkg::*;

   logic [25:0] prod;
   logic [9:0]  exp_s;
   logic [22:0] frac;
   logic        in_range;

   always_comb begin
      prod  = part.hh + {12'd0, part.hl_sh} + {12'd0, part.lh_sh} + 26'd2;
      exp_s = part.exp_zero ? 10'd0
            : 10'({2'b0, part.exp_a} + {2'b0, part.exp_b} - 10'(ExpBias));
      // a product of two or more (bit 25 set) shifts one bit further and bumps the exponent
      if (prod[25]) begin
         exp_s = exp_s + 10'd1;
         frac  = prod[24:2];
      end else begin
         frac  = prod[23:1];
      end
      // bit 9 set means negative, bit 8 set means above 255
      in_range = !exp_s[9] && !exp_s[8];
      if (part.zero_in || !in_range) begin
         product = {part.sign, 31'd0};
      end else begin
         product = {part.sign, exp_s[7:0], frac};
      end
   end
endmodule

### hw/rtl/asfm_checker.sv
// Port checker for the approximate float multiplier, bound to the top level.
module asfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   // stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   // nothing out the cycle after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an input accepted while the result register is empty yields a valid result via the input and result registers
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result missing");

   // input only blocked when the result side is full
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without cause");
endmodule

bind approx_single_float_multiplier asfm_checker u_asfm_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
